[design/dppt_pkg.sv]
// Shared types, widths and register codes of the depth pixel to point unit.
package dppt_pkg;

  // Width of the raster position counters.
  localparam int COORD_BITS = 12;

  // Fixed widths of the ports.
  localparam int PIX_W    = 12;
  localparam int DEPTH_W  = 16;
  localparam int SCALE_W  = 16;
  localparam int CENTRE_W = 13;
  localparam int INV_W    = 32;
  localparam int SIZE_W   = 13;
  localparam int COLOR_W  = 8;
  localparam int POINT_W  = 44;
  localparam int Z_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Offset magnitude |2*coord - centre| and frame limit compare widths.
  localparam int MAG_W = (COORD_BITS + 1 > CENTRE_W) ? COORD_BITS + 1 : CENTRE_W;
  localparam int LIM_W = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;

  // Shared multiplier and products.
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int A_W    = 48;  // |offset| * z
  localparam int HP_W   = 49;  // upper part of |offset| * z * inv

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MULT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X_HALF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y_HALF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_FOCAL_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_FOCAL_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 3'd6;

  // Register reset values.
  localparam logic [SCALE_W-1:0]  RST_DEPTH_MULT    = 16'd256;
  localparam logic [CENTRE_W-1:0] RST_CENTRE_X_HALF = 13'd639;
  localparam logic [CENTRE_W-1:0] RST_CENTRE_Y_HALF = 13'd479;
  localparam logic [INV_W-1:0]    RST_INVERSE_FOCAL = 32'd7531067;
  localparam logic [SIZE_W-1:0]   RST_FRAME_WIDTH   = 13'd640;
  localparam logic [SIZE_W-1:0]   RST_FRAME_HEIGHT  = 13'd480;

  typedef struct packed {
    logic [SCALE_W-1:0]  depth_mult;
    logic [CENTRE_W-1:0] centre_x_half;
    logic [CENTRE_W-1:0] centre_y_half;
    logic [INV_W-1:0]    inverse_focal_x;
    logic [INV_W-1:0]    inverse_focal_y;
    logic [SIZE_W-1:0]   frame_width;
    logic [SIZE_W-1:0]   frame_height;
  } cfg_t;

  // Which product the shared multiplier forms this cycle.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_Z,
    MUL_AX,
    MUL_AY,
    MUL_LX,
    MUL_HX,
    MUL_LY,
    MUL_HY
  } mul_sel_e;

  typedef struct packed {
    logic     accept;
    logic     load_out;
    mul_sel_e mul_sel;
  } cmd_t;

  typedef struct packed {
    logic depth_ok;
  } status_t;

endpackage

[design/depth_pixel_to_point_unit.sv]
// Top level of the depth pixel to point unit: back-projects depth pixels to 3-D points.
//
//  channel   direction  handshake                  payload
//  --------  ---------  -------------------------  ------------------------------------
//  pixel in  input      in_valid_i / in_ready_o    depth_raw, red/green/blue_in, frame_start
//  point out output     out_valid_o / out_ready_i  point_x/y/z, red/green/blue_out, column, row
//  config    input      cfg_we_i (no stall)        cfg_index_i, cfg_data_i
//
// A pixel with no depth costs no busy time: the counters advance and no word is made.
// A pixel with depth holds the input from its accept through eight
// sequencer steps, the last of which loads the result register. The single shared
// 32x32 multiplier forms seven products in turn (z, two offsets times z, and two
// partial products per axis against the inverse focal length).
// The result register parts the two sides: the next pixel is taken while a point
// waits; a stalled output only holds the sequencer in its last step.
// Reset clears counters, the sequencer, the valid flag and loads the default camera.
module depth_pixel_to_point_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [dppt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dppt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // pixel in
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dppt_pkg::DEPTH_W-1:0]        depth_raw_i,
  input  logic [dppt_pkg::COLOR_W-1:0]        red_in_i,
  input  logic [dppt_pkg::COLOR_W-1:0]        green_in_i,
  input  logic [dppt_pkg::COLOR_W-1:0]        blue_in_i,
  input  logic                                frame_start_i,
  // point out
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [dppt_pkg::POINT_W-1:0] point_x_o,
  output logic signed [dppt_pkg::POINT_W-1:0] point_y_o,
  output logic [dppt_pkg::Z_W-1:0]            point_z_o,
  output logic [dppt_pkg::COLOR_W-1:0]        red_out_o,
  output logic [dppt_pkg::COLOR_W-1:0]        green_out_o,
  output logic [dppt_pkg::COLOR_W-1:0]        blue_out_o,
  output logic [dppt_pkg::PIX_W-1:0]          pixel_column_o,
  output logic [dppt_pkg::PIX_W-1:0]          pixel_row_o
);

  dppt_pkg::cfg_t    cfg;
  dppt_pkg::cmd_t    cmd;
  dppt_pkg::status_t status;

  // Camera and frame registers.
  dppt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Sequencer: owns both handshakes and steps the multiplier.
  dppt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Counters, arithmetic and the result register.
  dppt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .status_o       (status),
    .depth_raw_i    (depth_raw_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .frame_start_i  (frame_start_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .point_z_o      (point_z_o),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .pixel_column_o (pixel_column_o),
    .pixel_row_o    (pixel_row_o)
  );

endmodule

[design/dppt_cfg.sv]
// Configuration register file of the depth pixel to point unit.
module dppt_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dppt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dppt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output dppt_pkg::cfg_t                      cfg_o
);

  dppt_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        dppt_pkg::CFG_DEPTH_MULT:
          cfg_d.depth_mult = cfg_data_i[dppt_pkg::SCALE_W-1:0];
        dppt_pkg::CFG_CENTRE_X_HALF:
          cfg_d.centre_x_half = cfg_data_i[dppt_pkg::CENTRE_W-1:0];
        dppt_pkg::CFG_CENTRE_Y_HALF:
          cfg_d.centre_y_half = cfg_data_i[dppt_pkg::CENTRE_W-1:0];
        dppt_pkg::CFG_INVERSE_FOCAL_X:
          cfg_d.inverse_focal_x = cfg_data_i[dppt_pkg::INV_W-1:0];
        dppt_pkg::CFG_INVERSE_FOCAL_Y:
          cfg_d.inverse_focal_y = cfg_data_i[dppt_pkg::INV_W-1:0];
        dppt_pkg::CFG_FRAME_WIDTH:
          cfg_d.frame_width = cfg_data_i[dppt_pkg::SIZE_W-1:0];
        dppt_pkg::CFG_FRAME_HEIGHT:
          cfg_d.frame_height = cfg_data_i[dppt_pkg::SIZE_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_mult      <= dppt_pkg::RST_DEPTH_MULT;
      cfg_q.centre_x_half   <= dppt_pkg::RST_CENTRE_X_HALF;
      cfg_q.centre_y_half   <= dppt_pkg::RST_CENTRE_Y_HALF;
      cfg_q.inverse_focal_x <= dppt_pkg::RST_INVERSE_FOCAL;
      cfg_q.inverse_focal_y <= dppt_pkg::RST_INVERSE_FOCAL;
      cfg_q.frame_width     <= dppt_pkg::RST_FRAME_WIDTH;
      cfg_q.frame_height    <= dppt_pkg::RST_FRAME_HEIGHT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/dppt_ctrl.sv]
// Sequencing state machine of the depth pixel to point unit.
module dppt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dppt_pkg::status_t status_i,
  output dppt_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Z,
    ST_AX,
    ST_AY,
    ST_LX,
    ST_HX,
    ST_LY,
    ST_HY,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // Result register is free when empty or being drained this cycle.
  assign load       = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && status_i.depth_ok) state_d = ST_Z;
      ST_Z:    state_d = ST_AX;
      ST_AX:   state_d = ST_AY;
      ST_AY:   state_d = ST_LX;
      ST_LX:   state_d = ST_HX;
      ST_HX:   state_d = ST_LY;
      ST_LY:   state_d = ST_HY;
      ST_HY:   state_d = ST_DONE;
      ST_DONE: if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    cmd_o.accept   = accept;
    cmd_o.load_out = load;
    case (state_q)
      ST_Z:    cmd_o.mul_sel = dppt_pkg::MUL_Z;
      ST_AX:   cmd_o.mul_sel = dppt_pkg::MUL_AX;
      ST_AY:   cmd_o.mul_sel = dppt_pkg::MUL_AY;
      ST_LX:   cmd_o.mul_sel = dppt_pkg::MUL_LX;
      ST_HX:   cmd_o.mul_sel = dppt_pkg::MUL_HX;
      ST_LY:   cmd_o.mul_sel = dppt_pkg::MUL_LY;
      ST_HY:   cmd_o.mul_sel = dppt_pkg::MUL_HY;
      default: cmd_o.mul_sel = dppt_pkg::MUL_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/dppt_dp.sv]
// Datapath: raster counters, shared 32x32 multiplier and result register.
module dppt_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dppt_pkg::cfg_t                         cfg_i,
  input  dppt_pkg::cmd_t                         cmd_i,
  output dppt_pkg::status_t                      status_o,
  input  logic [dppt_pkg::DEPTH_W-1:0]           depth_raw_i,
  input  logic [dppt_pkg::COLOR_W-1:0]           red_in_i,
  input  logic [dppt_pkg::COLOR_W-1:0]           green_in_i,
  input  logic [dppt_pkg::COLOR_W-1:0]           blue_in_i,
  input  logic                                   frame_start_i,
  output logic signed [dppt_pkg::POINT_W-1:0]    point_x_o,
  output logic signed [dppt_pkg::POINT_W-1:0]    point_y_o,
  output logic [dppt_pkg::Z_W-1:0]               point_z_o,
  output logic [dppt_pkg::COLOR_W-1:0]           red_out_o,
  output logic [dppt_pkg::COLOR_W-1:0]           green_out_o,
  output logic [dppt_pkg::COLOR_W-1:0]           blue_out_o,
  output logic [dppt_pkg::PIX_W-1:0]             pixel_column_o,
  output logic [dppt_pkg::PIX_W-1:0]             pixel_row_o
);

  localparam int CB    = dppt_pkg::COORD_BITS;
  localparam int MAG_W = dppt_pkg::MAG_W;
  localparam int LIM_W = dppt_pkg::LIM_W;
  localparam int MUL_W = dppt_pkg::MUL_W;
  localparam int A_W   = dppt_pkg::A_W;
  localparam int HP_W  = dppt_pkg::HP_W;
  localparam int PW    = dppt_pkg::POINT_W;
  localparam int Q_W   = HP_W - 1;
  localparam logic [LIM_W-1:0] COORD_CAP = LIM_W'(2 ** CB);

  // Floor of a signed quotient from magnitude, sticky bits and sign:
  // -(q + c) is ~q when c is set and ~q + 1 otherwise.
  function automatic logic [PW-1:0] finish(input logic [HP_W-1:0] hp,
                                           input logic sticky,
                                           input logic neg);
    logic [Q_W-1:0] q;
    logic [Q_W-1:0] r;
    q = hp[HP_W-1:1];
    if (!neg) begin
      r = q;
    end else if (hp[0] || sticky) begin
      r = ~q;
    end else begin
      r = ~q + Q_W'(1);
    end
    return r[PW-1:0];
  endfunction

  // Frame limit capped at the counter range.
  function automatic logic [LIM_W-1:0] cap_limit(input logic [dppt_pkg::SIZE_W-1:0] v);
    logic [LIM_W-1:0] w;
    w = LIM_W'(v);
    return (w > COORD_CAP) ? COORD_CAP : w;
  endfunction

  // Raster counters.
  logic [CB-1:0]    col_q, row_q, col_d, row_d, cur_col, cur_row;
  logic [CB:0]      col_inc, row_inc;
  logic             col_wrap, row_wrap;

  // Working registers of the word in flight.
  logic [dppt_pkg::DEPTH_W-2:0] depth_q;
  logic [dppt_pkg::COLOR_W-1:0] red_q, green_q, blue_q;
  logic [CB-1:0]                pcol_q, prow_q;
  logic                         negx_q, negy_q;
  logic [MAG_W-1:0]             magx_q, magy_q;
  logic [dppt_pkg::Z_W-1:0]     z_q;
  logic [A_W-1:0]               ax_q, ay_q;
  logic [dppt_pkg::PROD_W-1:0]  lp_q;
  logic [HP_W-1:0]              hp_q;
  logic                         stk_q;
  logic [PW-1:0]                px_q;

  // Offset from the principal point.
  logic [MAG_W-1:0] twice_x, twice_y, cx, cy;
  logic             negx_d, negy_d;
  logic [MAG_W-1:0] magx_d, magy_d;

  // Shared multiplier.
  logic [MUL_W-1:0]            mul_a, mul_b;
  logic [dppt_pkg::PROD_W-1:0] prod;
  logic [HP_W-1:0]             hp_d;

  assign status_o.depth_ok = (depth_raw_i != '0) && !depth_raw_i[dppt_pkg::DEPTH_W-1];

  always_comb begin
    cur_col  = frame_start_i ? '0 : col_q;
    cur_row  = frame_start_i ? '0 : row_q;
    col_inc  = {1'b0, cur_col} + (CB + 1)'(1);
    row_inc  = {1'b0, cur_row} + (CB + 1)'(1);
    col_wrap = LIM_W'(col_inc) >= cap_limit(cfg_i.frame_width);
    row_wrap = LIM_W'(row_inc) >= cap_limit(cfg_i.frame_height);
    col_d    = col_wrap ? '0 : col_inc[CB-1:0];
    row_d    = !col_wrap ? cur_row : (row_wrap ? '0 : row_inc[CB-1:0]);
  end

  always_comb begin
    twice_x = MAG_W'({cur_col, 1'b0});
    twice_y = MAG_W'({cur_row, 1'b0});
    cx      = MAG_W'(cfg_i.centre_x_half);
    cy      = MAG_W'(cfg_i.centre_y_half);
    negx_d  = twice_x < cx;
    negy_d  = twice_y < cy;
    magx_d  = negx_d ? cx - twice_x : twice_x - cx;
    magy_d  = negy_d ? cy - twice_y : twice_y - cy;
  end

  always_comb begin
    case (cmd_i.mul_sel)
      dppt_pkg::MUL_Z: begin
        mul_a = MUL_W'(depth_q);
        mul_b = MUL_W'(cfg_i.depth_mult);
      end
      dppt_pkg::MUL_AX: begin
        mul_a = MUL_W'(magx_q);
        mul_b = MUL_W'(z_q);
      end
      dppt_pkg::MUL_AY: begin
        mul_a = MUL_W'(magy_q);
        mul_b = MUL_W'(z_q);
      end
      dppt_pkg::MUL_LX: begin
        mul_a = ax_q[MUL_W-1:0];
        mul_b = cfg_i.inverse_focal_x;
      end
      dppt_pkg::MUL_HX: begin
        mul_a = MUL_W'(ax_q[A_W-1:MUL_W]);
        mul_b = cfg_i.inverse_focal_x;
      end
      dppt_pkg::MUL_LY: begin
        mul_a = ay_q[MUL_W-1:0];
        mul_b = cfg_i.inverse_focal_y;
      end
      dppt_pkg::MUL_HY: begin
        mul_a = MUL_W'(ay_q[A_W-1:MUL_W]);
        mul_b = cfg_i.inverse_focal_y;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign hp_d = prod[HP_W-1:0] + HP_W'(lp_q[dppt_pkg::PROD_W-1:MUL_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      depth_q <= depth_raw_i[dppt_pkg::DEPTH_W-2:0];
      red_q   <= red_in_i;
      green_q <= green_in_i;
      blue_q  <= blue_in_i;
      pcol_q  <= cur_col;
      prow_q  <= cur_row;
      negx_q  <= negx_d;
      negy_q  <= negy_d;
      magx_q  <= magx_d;
      magy_q  <= magy_d;
    end
    case (cmd_i.mul_sel)
      dppt_pkg::MUL_Z:  z_q  <= prod[dppt_pkg::Z_W-1:0];
      dppt_pkg::MUL_AX: ax_q <= prod[A_W-1:0];
      dppt_pkg::MUL_AY: ay_q <= prod[A_W-1:0];
      dppt_pkg::MUL_LX: lp_q <= prod;
      dppt_pkg::MUL_LY: begin
        lp_q <= prod;
        px_q <= finish(hp_q, stk_q, negx_q);
      end
      dppt_pkg::MUL_HX, dppt_pkg::MUL_HY: begin
        hp_q  <= hp_d;
        stk_q <= (lp_q[MUL_W-1:0] != '0);
      end
      default: ;
    endcase
    if (cmd_i.load_out) begin
      point_x_o      <= px_q;
      point_y_o      <= finish(hp_q, stk_q, negy_q);
      point_z_o      <= z_q;
      red_out_o      <= red_q;
      green_out_o    <= green_q;
      blue_out_o     <= blue_q;
      pixel_column_o <= dppt_pkg::PIX_W'(pcol_q);
      pixel_row_o    <= dppt_pkg::PIX_W'(prow_q);
    end
  end

endmodule

[design/dppt_checker.sv]
// Port-level checks of the depth pixel to point unit, bound to its top level.
module dppt_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic [dppt_pkg::DEPTH_W-1:0]        depth_raw_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [dppt_pkg::POINT_W-1:0] point_x_o,
  input logic signed [dppt_pkg::POINT_W-1:0] point_y_o,
  input logic [dppt_pkg::Z_W-1:0]            point_z_o
);

  // A stalled point holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(point_x_o) && $stable(point_y_o) && $stable(point_z_o))
    else $error("stalled point word changed");

  // A pixel without depth costs no busy time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
      (depth_raw_i == '0 || depth_raw_i[dppt_pkg::DEPTH_W-1]) |=> in_ready_o)
    else $error("no-depth pixel stalled the input");

  // A pixel with depth occupies the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && depth_raw_i != '0 &&
      !depth_raw_i[dppt_pkg::DEPTH_W-1] |=> !in_ready_o)
    else $error("input taken while a point is being computed");

  // Loading a point frees the input side in the same step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("point appeared without the sequencer returning to idle");

endmodule

bind depth_pixel_to_point_unit dppt_checker u_dppt_checker (.*);
